/* hw/rtl/mbet_pkg.sv */
// mbet_pkg: shared types and constants of the escape-time evaluator
// no dependencies
`default_nettype none
package mbet_pkg;
	localparam int MaxIter = 1000;
	localparam int CoordBits = 12;
	localparam int FracBits = 28;
	localparam int ZW = 64;
	localparam logic [41:0] MagLim = 42'h3FF_FFFF_FFFF;
	localparam logic signed [63:0] EscapeSq = 64'sd10000 <<< 28;
	localparam logic signed [31:0] SmoothBias = 32'sd165725;

	localparam logic [2:0] REG_ZOOM = 3'd0;
	localparam logic [2:0] REG_CRE = 3'd1;
	localparam logic [2:0] REG_CIM = 3'd2;
	localparam logic [2:0] REG_WID = 3'd3;
	localparam logic [2:0] REG_HGT = 3'd4;

	// mapped point handed from front to back
	typedef struct packed {
		logic signed [31:0] cr;
		logic signed [31:0] ci;
	} point_t;

	// result of one pixel
	typedef struct packed {
		logic in_set;
		logic [9:0] iter;
		logic signed [15:0] smooth;
	} result_t;
endpackage
`default_nettype wire

/* hw/rtl/mbet_div.sv */
// mbet_div: restoring divider, one quotient bit per cycle
// depends on mbet_pkg
`default_nettype none
module mbet_div
	import mbet_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [45:0] dividend,
	input  wire logic [13:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [45:0]      quotient
);
	logic [5:0]  cnt_q;
	logic [45:0] quo_q;
	logic [14:0] rem_q;
	logic [13:0] dvs_q;
	logic [14:0] trial;

	assign trial = {rem_q[13:0], quo_q[45]};

	// shift and subtract
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy  <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				cnt_q <= 6'd46;
			end else if (busy) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				quo_q <= {quo_q[44:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[44:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
endmodule
`default_nettype wire

/* hw/rtl/mbet_front.sv */
// mbet_front: maps a pixel to a complex point
// depends on mbet_pkg, mbet_div
`default_nettype none
module mbet_front
	import mbet_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CoordBits-1:0] px,
	input  wire logic [CoordBits-1:0] py,
	input  wire logic [30:0]          zoom,
	input  wire logic [31:0]          cre,
	input  wire logic [31:0]          cim,
	input  wire logic [12:0]          wid,
	input  wire logic [12:0]          hgt,
	output logic                      pt_valid,
	input  wire logic                 pt_ready,
	output point_t                    pt
);
	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MULX = 3'd1;
	localparam logic [2:0] F_DIVX = 3'd2;
	localparam logic [2:0] F_MULY = 3'd3;
	localparam logic [2:0] F_DIVY = 3'd4;
	localparam logic [2:0] F_OUT  = 3'd5;

	logic [2:0]  st_q;
	logic [CoordBits-1:0] py_q;
	logic        neg_q;
	logic [45:0] mag_q;
	logic [13:0] dvs;
	logic        dstart, dbusy, ddone;
	logic [45:0] quo;
	logic signed [33:0] sum;
	logic signed [31:0] sat;
	logic signed [31:0] cr_q;
	logic signed [14:0] diff;
	logic [14:0] dmag;
	logic [12:0] big;

	// x offset taken straight from the input while idle, y offset from the held row
	assign big = (wid > hgt) ? wid : ((hgt == 13'd0) ? 13'd1 : hgt);
	assign dvs = {big, 1'b0};
	assign diff = (st_q == F_IDLE) ? $signed({2'b0, px, 1'b0}) - $signed({2'b0, wid})
		: $signed({2'b0, py_q, 1'b0}) - $signed({2'b0, hgt});
	assign dmag = diff[14] ? 15'(-diff) : diff;
	assign dstart = (st_q == F_MULX) || (st_q == F_MULY);

	mbet_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(mag_q),
		.divisor(dvs), .busy(dbusy), .done(ddone), .quotient(quo)
	);

	// centre plus signed quotient, saturated
	assign sum = $signed({{2{(st_q == F_DIVX) ? cre[31] : cim[31]}},
		(st_q == F_DIVX) ? cre : cim})
		+ (neg_q ? -$signed({1'b0, quo[32:0]}) : $signed({1'b0, quo[32:0]}));
	always_comb begin
		if (|quo[45:32]) sat = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else if (sum > 34'sh0_7FFF_FFFF) sat = 32'sh7FFF_FFFF;
		else if (sum < -34'sh0_8000_0000) sat = 32'sh8000_0000;
		else sat = sum[31:0];
	end

	assign in_ready = (st_q == F_IDLE);
	assign pt_valid = (st_q == F_OUT);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			case (st_q)
				F_IDLE: if (in_valid) st_q <= F_MULX;
				F_MULX: st_q <= F_DIVX;
				F_DIVX: if (ddone) st_q <= F_MULY;
				F_MULY: st_q <= F_DIVY;
				F_DIVY: if (ddone) st_q <= F_OUT;
				F_OUT:  if (pt_ready) st_q <= F_IDLE;
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == F_IDLE && in_valid) begin
			py_q <= py;
		end
		if (st_q == F_IDLE) begin
			mag_q <= 46'(dmag) * 46'(zoom);
			neg_q <= diff[14];
		end
		if (st_q == F_DIVX && ddone) begin
			cr_q  <= sat;
			mag_q <= 46'(dmag) * 46'(zoom);
			neg_q <= diff[14];
		end
		if (st_q == F_DIVY && ddone) begin
			pt.cr <= cr_q;
			pt.ci <= sat;
		end
	end

	// a division only starts on an idle divider
	assert property (@(posedge clk) disable iff (!arst_n) dstart |-> !dbusy)
		else $error("division started while busy");
endmodule
`default_nettype wire

/* hw/rtl/mbet_back.sv */
// mbet_back: iterates z = z^2 + c and forms the smoothing term
// depends on mbet_pkg
`default_nettype none
module mbet_back
	import mbet_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pt_valid,
	output logic      pt_ready,
	input  point_t    pt,
	output logic      res_valid,
	input  wire logic res_ready,
	output result_t   res
);
	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_M1   = 4'd1;
	localparam logic [3:0] B_M2   = 4'd2;
	localparam logic [3:0] B_M3   = 4'd3;
	localparam logic [3:0] B_UPD  = 4'd4;
	localparam logic [3:0] B_S1   = 4'd5;
	localparam logic [3:0] B_S2   = 4'd6;
	localparam logic [3:0] B_CHK  = 4'd7;
	localparam logic [3:0] B_LOG  = 4'd8;
	localparam logic [3:0] B_DONE = 4'd9;
	localparam logic [3:0] B_OUT  = 4'd10;

	logic [3:0] st_q;
	logic signed [63:0] cr_q, ci_q, zr_q, zi_q, mrr_q, mii_q, mri_q, m_q;
	logic [9:0] it_q;
	logic signed [63:0] ma, mb, prod;
	logic [41:0] sa, sb;
	logic [83:0] full;
	logic [83:0] acc_q;
	logic [1:0]  mph_q;
	logic        mul_st, mul_last;
	logic [20:0] pa, pb;
	logic [41:0] pp;
	logic        pneg;
	logic [63:0] ua, ub;

	// operand select and saturation for the shared multiplier
	always_comb begin
		case (st_q)
			B_M1: begin ma = zr_q; mb = zr_q; end
			B_M2: begin ma = zi_q; mb = zi_q; end
			B_S1: begin ma = zr_q; mb = zr_q; end
			B_S2: begin ma = zi_q; mb = zi_q; end
			default: begin ma = zr_q; mb = zi_q; end
		endcase
		ua = ma[63] ? 64'(-ma) : ma;
		ub = mb[63] ? 64'(-mb) : mb;
		sa = (ua > 64'(MagLim)) ? MagLim : ua[41:0];
		sb = (ub > 64'(MagLim)) ? MagLim : ub[41:0];
		pneg = ma[63] ^ mb[63];
	end

	// four 21x21 partial products accumulated in turn, product ready in the last phase
	assign mul_st = (st_q == B_M1) || (st_q == B_M2) || (st_q == B_M3)
		|| (st_q == B_S1) || (st_q == B_S2);
	assign mul_last = (mph_q == 2'd3);
	assign pa = mph_q[1] ? sa[41:21] : sa[20:0];
	assign pb = mph_q[0] ? sb[41:21] : sb[20:0];
	assign pp = 42'(pa) * 42'(pb);
	always_comb begin
		case (mph_q)
			2'd0: full = 84'(pp);
			2'd1, 2'd2: full = acc_q + (84'(pp) << 21);
			default: full = acc_q + (84'(pp) << 42);
		endcase
	end
	assign prod = pneg ? -$signed(64'(full >> FracBits)) : $signed(64'(full >> FracBits));

	// partial product phase and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mph_q <= '0;
		end else if (mul_st) begin
			mph_q <= mph_q + 2'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (mul_st) acc_q <= full;
	end

	// log2 unit: normalise then 16 squarings, one per cycle
	logic [1:0]  lpass_q;
	logic [4:0]  lk_q;
	logic [5:0]  lp_q;
	logic [31:0] lm_q;
	logic [15:0] lf_q;
	logic signed [31:0] l1_q;
	logic [63:0] lsq;
	logic [63:0] lin;
	logic [5:0]  lpos;
	always_comb begin
		lpos = '0;
		for (int b = 0; b < 64; b++) if (lin[b]) lpos = 6'(b);
	end
	assign lsq = (64'(lm_q) * 64'(lm_q)) >> 30;

	logic signed [31:0] lres, sterm;
	logic signed [36:0] rnd;
	assign lres = $signed({10'd0, lp_q, 16'd0}) | $signed({16'd0, lf_q});
	assign sterm = SmoothBias - (lres - 32'sd1048576);
	assign rnd = (37'(sterm) + 37'sd8) >>> 4;

	assign pt_ready = (st_q == B_IDLE);
	assign res_valid = (st_q == B_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			case (st_q)
				B_IDLE: if (pt_valid) st_q <= B_M1;
				B_M1: if (mul_last) st_q <= B_M2;
				B_M2: if (mul_last) st_q <= B_M3;
				B_M3: if (mul_last) st_q <= B_UPD;
				B_UPD: st_q <= B_S1;
				B_S1: if (mul_last) st_q <= B_S2;
				B_S2: if (mul_last) st_q <= B_CHK;
				B_CHK: begin
					if (m_q > EscapeSq) st_q <= B_LOG;
					else if (it_q == 10'(MaxIter - 1)) st_q <= B_OUT;
					else st_q <= B_M1;
				end
				B_LOG: if (lk_q == 5'd16 && lpass_q == 2'd1) st_q <= B_DONE;
				B_DONE: st_q <= B_OUT;
				B_OUT: if (res_ready) st_q <= B_IDLE;
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign lin = (lpass_q == 2'd0) ? 64'(m_q) : 64'(l1_q);

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				cr_q <= 64'(pt.cr);
				ci_q <= 64'(pt.ci);
				zr_q <= '0;
				zi_q <= '0;
				it_q <= '0;
				res.in_set <= 1'b1;
				res.iter <= '0;
				res.smooth <= '0;
			end
			B_M1: if (mul_last) mrr_q <= prod;
			B_M2: if (mul_last) mii_q <= prod;
			B_M3: if (mul_last) mri_q <= prod;
			B_UPD: begin
				zr_q <= mrr_q - mii_q + cr_q;
				zi_q <= (mri_q <<< 1) + ci_q;
			end
			B_S1: if (mul_last) mrr_q <= prod;
			B_S2: begin
				if (mul_last) begin
					m_q <= mrr_q + prod;
					lpass_q <= 2'd0;
					lk_q <= 5'd17;
				end
			end
			B_CHK: begin
				if (!(m_q > EscapeSq) && it_q != 10'(MaxIter - 1)) it_q <= it_q + 10'd1;
			end
			B_LOG: begin
				if (lk_q == 5'd17) begin
					lp_q <= lpos;
					lm_q <= (lpos >= 6'd30) ? 32'(lin >> (lpos - 6'd30))
						: 32'(lin << (6'd30 - lpos));
					lf_q <= '0;
					lk_q <= '0;
				end else if (lk_q < 5'd16) begin
					if (lsq[31]) begin
						lm_q <= lsq[32:1];
						lf_q <= {lf_q[14:0], 1'b1};
					end else begin
						lm_q <= lsq[31:0];
						lf_q <= {lf_q[14:0], 1'b0};
					end
					lk_q <= lk_q + 5'd1;
				end else begin
					l1_q <= lres - 32'sh1C0000;
					lpass_q <= 2'd1;
					lk_q <= 5'd17;
				end
			end
			B_DONE: begin
				res.in_set <= 1'b0;
				res.iter <= it_q;
				if (rnd > 37'sd32767) res.smooth <= 16'sh7FFF;
				else if (rnd < -37'sd32768) res.smooth <= 16'sh8000;
				else res.smooth <= rnd[15:0];
			end
			default: ;
		endcase
	end

	// iteration counter never passes the limit
	assert property (@(posedge clk) disable iff (!arst_n) it_q <= 10'(MaxIter - 1) || st_q == B_IDLE)
		else $error("iteration count overrun");
	// an escaped result carries an index below the limit
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_OUT && !res.in_set) |-> res.iter <= 10'(MaxIter - 1))
		else $error("bad escape index");
	// result holds while waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_OUT && !res_ready) |=> $stable(res))
		else $error("result changed while stalled");
endmodule
`default_nettype wire

/* hw/rtl/mandelbrot_escape_time.sv */
// mandelbrot_escape_time: top level, config registers, front/back split
// depends on mbet_pkg, mbet_front, mbet_back
// Each iteration of z = z^2 + c runs its five products one after another on the
// shared multiplier, each as four partial products; a pixel inside the set runs
// all 1000 iterations, and an escaping pixel adds the two log2 passes. The front
// maps a pixel with two 46-step divisions, overlapped with the iterations of the
// previous pixel.
// tdata out: inside_set, escape_iteration, smooth_term from bit 0 up.
`default_nettype none
module mandelbrot_escape_time
	import mbet_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // inside_set[0], escape_iteration[10:1], smooth_term[26:11]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic [30:0] zoom_q;
	logic [31:0] cre_q, cim_q;
	logic [12:0] wid_q, hgt_q;
	logic        pv, pr;
	point_t      pt;
	result_t     res;

	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q <= 31'd805306368;
			cre_q  <= 32'hF800_0000;
			cim_q  <= '0;
			wid_q  <= 13'd1000;
			hgt_q  <= 13'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ZOOM: zoom_q <= cfg_data[30:0];
				REG_CRE:  cre_q  <= cfg_data;
				REG_CIM:  cim_q  <= cfg_data;
				REG_WID:  wid_q  <= cfg_data[12:0];
				REG_HGT:  hgt_q  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	mbet_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.px(s_axis_tdata[11:0]), .py(s_axis_tdata[23:12]), .zoom(zoom_q), .cre(cre_q),
		.cim(cim_q), .wid(wid_q), .hgt(hgt_q), .pt_valid(pv), .pt_ready(pr), .pt(pt)
	);

	mbet_back u_back (
		.clk(clk), .arst_n(arst_n), .pt_valid(pv), .pt_ready(pr), .pt(pt),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {5'd0, res.smooth, res.iter, res.in_set};
endmodule
`default_nettype wire
